// File: rtl/sorted_priority_queue_macros.svh
// Assertion macros used by the sorted priority queue module.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while reset is held.
`define SPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: assertion failed");

// Next-cycle implication, sampled on clk and disabled while reset is held.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: assertion failed");

`endif

// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the sorted priority queue modules.
package spq_pkg;

    localparam int COORD_W = 8;
    localparam int COST_W  = 14;
    localparam int OCC_W   = 7;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    localparam logic [COST_W-1:0] COST_MAX = 14'd10000;

    localparam logic [OP_W-1:0] OP_ENQUEUE  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } spq_state_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] tile_x;
        logic [COORD_W-1:0] tile_y;
        logic [COST_W-1:0]  cost;
    } spq_cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COST_W-1:0]  out_cost;
        logic               found;
        logic [STAT_W-1:0]  status;
        logic [OCC_W-1:0]   occupancy;
    } spq_rsp_t;

    typedef struct packed {
        logic insert;
        logic take_next;
    } spq_cell_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and trades it with its neighbours.
module spq_cell #(
    parameter int CW = 8
) (
    input  logic                         clk,
    input  spq_pkg::spq_cell_ctrl_t      ctrl,
    input  logic                         occupied,
    input  logic [CW-1:0]                ins_x,
    input  logic [CW-1:0]                ins_y,
    input  logic [spq_pkg::COST_W-1:0]   ins_cost,
    input  logic [CW-1:0]                key_x,
    input  logic [CW-1:0]                key_y,
    input  logic                         prev_gt,
    input  logic [CW-1:0]                prev_x,
    input  logic [CW-1:0]                prev_y,
    input  logic [spq_pkg::COST_W-1:0]   prev_cost,
    input  logic [CW-1:0]                next_x,
    input  logic [CW-1:0]                next_y,
    input  logic [spq_pkg::COST_W-1:0]   next_cost,
    output logic [CW-1:0]                x,
    output logic [CW-1:0]                y,
    output logic [spq_pkg::COST_W-1:0]   cost,
    output logic                         gt,
    output logic                         match
);

    logic [CW-1:0]              x_reg;
    logic [CW-1:0]              x_next;
    logic [CW-1:0]              y_reg;
    logic [CW-1:0]              y_next;
    logic [spq_pkg::COST_W-1:0] cost_reg;
    logic [spq_pkg::COST_W-1:0] cost_next;

    // The new entry goes behind every stored entry of strictly lower cost.
    assign gt    = occupied && (ins_cost > cost_reg);
    assign match = occupied && (x_reg == key_x) && (y_reg == key_y);

    assign x    = x_reg;
    assign y    = y_reg;
    assign cost = cost_reg;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        cost_next = cost_reg;
        priority if (ctrl.insert)
        begin
            // Cells ahead of the insertion point keep their entry; the first
            // cell past it takes the new entry and the rest move back one.
            if (!gt)
            begin
                if (prev_gt)
                begin
                    x_next    = ins_x;
                    y_next    = ins_y;
                    cost_next = ins_cost;
                end
                else
                begin
                    x_next    = prev_x;
                    y_next    = prev_y;
                    cost_next = prev_cost;
                end
            end
        end
        else if (ctrl.take_next)
        begin
            x_next    = next_x;
            y_next    = next_y;
            cost_next = next_cost;
        end
        else
        begin
            x_next    = x_reg;
            y_next    = y_reg;
            cost_next = cost_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        cost_reg <= cost_next;
    end

endmodule

// File: rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Enqueue, dequeue, flush and unused codes finish in the cycle of the transfer.
// Remove and contains scan the cell chain one slot per cycle, up to the matching slot
// (or up to the occupancy when there is no match); the next command is taken once the result is out.
// Throughput: one enqueue, dequeue or flush per cycle unless rsp stalls; output is registered.
// Reset: the entry count clears to zero at once, so the queue starts empty with no clearing pass.
module sorted_priority_queue #(
    parameter int CAPACITY   = 64,
    parameter int COORD_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  spq_pkg::spq_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output spq_pkg::spq_rsp_t rsp
);

`include "sorted_priority_queue_macros.svh"

    localparam int CW    = (COORD_BITS < spq_pkg::COORD_W) ? COORD_BITS : spq_pkg::COORD_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    spq_pkg::spq_state_t state_reg;
    spq_pkg::spq_state_t state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    scan_reg;
    logic [CNT_W-1:0]    scan_next;
    logic [CW-1:0]       key_x_reg;
    logic [CW-1:0]       key_x_next;
    logic [CW-1:0]       key_y_reg;
    logic [CW-1:0]       key_y_next;
    logic                is_remove_reg;
    logic                is_remove_next;
    spq_pkg::spq_rsp_t   rsp_reg;
    spq_pkg::spq_rsp_t   rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    spq_pkg::spq_rsp_t   pend_reg;
    spq_pkg::spq_rsp_t   pend_next;

    spq_pkg::spq_rsp_t   res;
    logic                finish;
    logic                ins_en;
    logic                del_en;
    logic [CNT_W-1:0]    del_pos;
    logic                out_free;
    logic                in_range;
    logic                hit;
    logic [CW-1:0]       ins_x;
    logic [CW-1:0]       ins_y;
    logic [spq_pkg::COST_W-1:0] ins_cost;

    logic [CW-1:0]              x_arr    [CAPACITY];
    logic [CW-1:0]              y_arr    [CAPACITY];
    logic [spq_pkg::COST_W-1:0] cost_arr [CAPACITY];
    logic [CAPACITY-1:0]        gt_vec;
    logic [CAPACITY-1:0]        match_vec;
    spq_pkg::spq_cell_ctrl_t    cell_ctrl [CAPACITY];

    assign ins_x    = cmd.tile_x[CW-1:0];
    assign ins_y    = cmd.tile_y[CW-1:0];
    assign ins_cost = (cmd.cost > spq_pkg::COST_MAX) ? spq_pkg::COST_MAX : cmd.cost;

    assign cmd_ready = (state_reg == spq_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign in_range = (scan_reg < count_reg);
    assign hit      = in_range && match_vec[scan_reg[IDX_W-1:0]];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                       prev_gt;
        logic [CW-1:0]              prev_x;
        logic [CW-1:0]              prev_y;
        logic [spq_pkg::COST_W-1:0] prev_cost;
        logic [CW-1:0]              next_x;
        logic [CW-1:0]              next_y;
        logic [spq_pkg::COST_W-1:0] next_cost;

        if (i == 0)
        begin : g_head
            assign prev_gt   = 1'b1;
            assign prev_x    = ins_x;
            assign prev_y    = ins_y;
            assign prev_cost = ins_cost;
        end
        else
        begin : g_body
            assign prev_gt   = gt_vec[i-1];
            assign prev_x    = x_arr[i-1];
            assign prev_y    = y_arr[i-1];
            assign prev_cost = cost_arr[i-1];
        end

        // The tail cell falls out of the occupied range on a delete, so it may
        // keep whatever it holds.
        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_x    = x_arr[i];
            assign next_y    = y_arr[i];
            assign next_cost = cost_arr[i];
        end
        else
        begin : g_inner
            assign next_x    = x_arr[i+1];
            assign next_y    = y_arr[i+1];
            assign next_cost = cost_arr[i+1];
        end

        assign cell_ctrl[i].insert    = ins_en;
        assign cell_ctrl[i].take_next = del_en && (CNT_W'(i) >= del_pos);

        spq_cell #(
            .CW (CW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .occupied  (CNT_W'(i) < count_reg),
            .ins_x     (ins_x),
            .ins_y     (ins_y),
            .ins_cost  (ins_cost),
            .key_x     (key_x_reg),
            .key_y     (key_y_reg),
            .prev_gt   (prev_gt),
            .prev_x    (prev_x),
            .prev_y    (prev_y),
            .prev_cost (prev_cost),
            .next_x    (next_x),
            .next_y    (next_y),
            .next_cost (next_cost),
            .x         (x_arr[i]),
            .y         (y_arr[i]),
            .cost      (cost_arr[i]),
            .gt        (gt_vec[i]),
            .match     (match_vec[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        key_x_next     = key_x_reg;
        key_y_next     = key_y_reg;
        is_remove_next = is_remove_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        pend_next      = pend_reg;
        res            = '0;
        finish         = 1'b0;
        ins_en         = 1'b0;
        del_en         = 1'b0;
        del_pos        = '0;

        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.operation)
                        spq_pkg::OP_ENQUEUE:
                        begin
                            finish = 1'b1;
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res.status = spq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ins_en     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        spq_pkg::OP_DEQUEUE:
                        begin
                            finish = 1'b1;
                            if (count_reg == '0)
                            begin
                                res.status = spq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                res.out_x    = spq_pkg::COORD_W'(x_arr[0]);
                                res.out_y    = spq_pkg::COORD_W'(y_arr[0]);
                                res.out_cost = cost_arr[0];
                                del_en       = 1'b1;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        spq_pkg::OP_REMOVE, spq_pkg::OP_CONTAINS:
                        begin
                            key_x_next     = ins_x;
                            key_y_next     = ins_y;
                            is_remove_next = (cmd.operation == spq_pkg::OP_REMOVE);
                            scan_next      = '0;
                            state_next     = spq_pkg::S_SCAN;
                        end
                        spq_pkg::OP_FLUSH:
                        begin
                            finish     = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            spq_pkg::S_SCAN:
            begin
                // One slot is checked per cycle, front first, so the first
                // hit is the front-most match.
                priority if (!in_range)
                begin
                    finish     = 1'b1;
                    res.status = is_remove_reg ? spq_pkg::STAT_NOT_FOUND : spq_pkg::STAT_OK;
                end
                else if (hit)
                begin
                    finish = 1'b1;
                    if (is_remove_reg)
                    begin
                        del_en     = 1'b1;
                        del_pos    = scan_reg;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        res.found = 1'b1;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            spq_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase

        res.occupancy = spq_pkg::OCC_W'(count_next);

        // A finished result goes straight to the output register when it is
        // free, and otherwise waits in the pending register.
        if (finish)
        begin
            if (out_free)
            begin
                rsp_next       = res;
                rsp_valid_next = 1'b1;
                state_next     = spq_pkg::S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = spq_pkg::S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg      <= scan_next;
        key_x_reg     <= key_x_next;
        key_y_reg     <= key_y_next;
        is_remove_reg <= is_remove_next;
        rsp_reg       <= rsp_next;
        pend_reg      <= pend_next;
    end

    `SPQ_ASSERT_IMPL(a_count_bound, 1'b1, (count_reg <= CNT_W'(CAPACITY)))
    `SPQ_ASSERT_IMPL(a_front_sorted, (count_reg >= CNT_W'(2)), (cost_arr[0] <= cost_arr[1]))
    `SPQ_ASSERT_IMPL(a_hold_has_output, (state_reg == spq_pkg::S_HOLD), rsp_valid_reg)
    `SPQ_ASSERT_NEXT(a_enqueue_grows, (cmd_valid && cmd_ready && (cmd.operation == spq_pkg::OP_ENQUEUE) && (count_reg != CNT_W'(CAPACITY))), (count_reg == CNT_W'($past(count_reg) + 1'b1)))

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue: directed and random command traffic against a predictor.
module tb_top;

    import spq_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int QUIET_TAIL     = 150;
    localparam int LONG_HOLD_AT   = 600;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 100;

    // Operation codes the block treats as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_SEARCH,
        MIX_NOISE
    } traffic_mix_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    spq_cmd_t cmd       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    spq_rsp_t rsp;

    spq_cmd_t pending_cmds[$];
    spq_rsp_t awaited_rsp[$];
    spq_rsp_t predicted_rsp;
    spq_rsp_t due_rsp;

    logic [COORD_W-1:0] mirror_x[CAPACITY];
    logic [COORD_W-1:0] mirror_y[CAPACITY];
    logic [COST_W-1:0]  mirror_cost[CAPACITY];
    int                 mirror_count = 0;

    logic cmd_fire       = 1'b0;
    int   total_cmds     = 0;
    int   accepted_cmds  = 0;
    int   error_count    = 0;
    int   stall_cycles   = 0;
    int   send_gap       = 0;
    int   hold_left      = 0;
    bit   long_hold_done = 1'b0;

    sorted_priority_queue #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Index of the front-most entry on this tile, or the entry count when there is none.
    function automatic int find_tile(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int i;
        for (i = 0; i < mirror_count; i++)
        begin
            if (mirror_x[i] == x && mirror_y[i] == y)
                return i;
        end
        return mirror_count;
    endfunction

    task automatic drop_slot(input int pos);
        int i;
        for (i = pos; i < mirror_count - 1; i++)
        begin
            mirror_x[i]    = mirror_x[i + 1];
            mirror_y[i]    = mirror_y[i + 1];
            mirror_cost[i] = mirror_cost[i + 1];
        end
        mirror_count--;
    endtask

    task automatic predict_queue_result(input spq_cmd_t c, output spq_rsp_t r);
        logic [COST_W-1:0] clamped;
        int pos;
        int i;
        r = '0;
        r.status = STAT_OK;
        clamped = (c.cost > COST_MAX) ? COST_MAX : c.cost;
        case (c.operation)
            OP_ENQUEUE:
            begin
                if (mirror_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    // The new entry goes ahead of every entry of equal or greater cost.
                    pos = 0;
                    while (pos < mirror_count && clamped > mirror_cost[pos])
                        pos++;
                    for (i = mirror_count; i > pos; i--)
                    begin
                        mirror_x[i]    = mirror_x[i - 1];
                        mirror_y[i]    = mirror_y[i - 1];
                        mirror_cost[i] = mirror_cost[i - 1];
                    end
                    mirror_x[pos]    = c.tile_x;
                    mirror_y[pos]    = c.tile_y;
                    mirror_cost[pos] = clamped;
                    mirror_count++;
                end
            end
            OP_DEQUEUE:
            begin
                if (mirror_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.out_x    = mirror_x[0];
                    r.out_y    = mirror_y[0];
                    r.out_cost = mirror_cost[0];
                    drop_slot(0);
                end
            end
            OP_REMOVE:
            begin
                pos = find_tile(c.tile_x, c.tile_y);
                if (pos >= mirror_count)
                    r.status = STAT_NOT_FOUND;
                else
                    drop_slot(pos);
            end
            OP_CONTAINS:
            begin
                r.found = (find_tile(c.tile_x, c.tile_y) < mirror_count);
            end
            OP_FLUSH:
            begin
                mirror_count = 0;
            end
            default:
            begin
            end
        endcase
        r.occupancy = mirror_count[OCC_W-1:0];
    endtask

    task automatic add_cmd(input logic [OP_W-1:0] op, input int x, input int y, input int c);
        spq_cmd_t item;
        item.operation = op;
        item.tile_x    = x[COORD_W-1:0];
        item.tile_y    = y[COORD_W-1:0];
        item.cost      = c[COST_W-1:0];
        pending_cmds.push_back(item);
    endtask

    task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("rsp.%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    // Command driver: a new command or an idle cycle is set up after each transfer.
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_fire))
        begin
            if (cmd_fire && pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 9);
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd       <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Response receiver: short random stalls, one long hold-off, and none near the end.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (!long_hold_done && accepted_cmds >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                rsp_ready     <= 1'b0;
            end
            else if (accepted_cmds + QUIET_TAIL < total_cmds && $urandom_range(0, 9) == 0)
            begin
                hold_left  = $urandom_range(1, 9) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Monitor: a response is checked before the command of the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_fire <= cmd_valid && cmd_ready;
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $error("response transfer with no command outstanding");
                    error_count++;
                end
                else
                begin
                    due_rsp = awaited_rsp.pop_front();
                    check_field("out_x", due_rsp.out_x, rsp.out_x);
                    check_field("out_y", due_rsp.out_y, rsp.out_y);
                    check_field("out_cost", due_rsp.out_cost, rsp.out_cost);
                    check_field("found", due_rsp.found, rsp.found);
                    check_field("status", due_rsp.status, rsp.status);
                    check_field("occupancy", due_rsp.occupancy, rsp.occupancy);
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                predict_queue_result(cmd, predicted_rsp);
                awaited_rsp.push_back(predicted_rsp);
                accepted_cmds++;
            end
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb_top: done, errors");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        traffic_mix_t mix;
        int random_count;
        int phase_len;
        int k;
        int pick;
        int x;
        int y;
        int c;
        bit narrow;
        logic [OP_W-1:0] op;

        // Directed opening: empty-queue faults, clamping, ties, duplicate tiles and spare codes.
        add_cmd(OP_DEQUEUE, 0, 0, 0);
        add_cmd(OP_REMOVE, 5, 5, 0);
        add_cmd(OP_CONTAINS, 5, 5, 0);
        add_cmd(OP_ENQUEUE, 0, 0, 0);
        add_cmd(OP_ENQUEUE, 255, 255, 10000);
        add_cmd(OP_ENQUEUE, 255, 0, 16383);
        add_cmd(OP_ENQUEUE, 0, 255, 0);
        add_cmd(OP_ENQUEUE, 7, 7, 50);
        add_cmd(OP_ENQUEUE, 7, 7, 20);
        add_cmd(OP_CONTAINS, 255, 255, 16383);
        add_cmd(OP_REMOVE, 7, 7, 0);
        add_cmd(OP_REMOVE, 255, 0, 0);
        add_cmd(OP_SPARE_A, 1, 2, 3);
        add_cmd(OP_SPARE_B, 0, 0, 0);
        add_cmd(OP_SPARE_C, 255, 255, 16383);
        add_cmd(OP_DEQUEUE, 0, 0, 0);
        add_cmd(OP_DEQUEUE, 255, 255, 16383);
        add_cmd(OP_DEQUEUE, 0, 0, 0);
        add_cmd(OP_FLUSH, 0, 0, 0);
        add_cmd(OP_DEQUEUE, 0, 0, 0);
        add_cmd(OP_CONTAINS, 255, 255, 0);
        add_cmd(OP_FLUSH, 255, 255, 16383);

        // Random phases: fill runs push toward the full queue, drain runs toward the empty one, and a
        // narrow coordinate pool makes remove and contains hit stored tiles often.
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            mix       = traffic_mix_t'($urandom_range(0, 3));
            phase_len = $urandom_range(40, 160);
            narrow    = 1'($urandom_range(0, 1));
            for (k = 0; k < phase_len && random_count < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:
                        op = (pick < 85) ? OP_ENQUEUE : (pick < 90) ? OP_DEQUEUE :
                             (pick < 94) ? OP_REMOVE : (pick < 99) ? OP_CONTAINS : OP_SPARE_A;
                    MIX_DRAIN:
                        op = (pick < 20) ? OP_ENQUEUE : (pick < 75) ? OP_DEQUEUE :
                             (pick < 85) ? OP_REMOVE : (pick < 95) ? OP_CONTAINS :
                             (pick < 97) ? OP_FLUSH : OP_SPARE_B;
                    MIX_SEARCH:
                        op = (pick < 40) ? OP_ENQUEUE : (pick < 60) ? OP_DEQUEUE :
                             (pick < 78) ? OP_REMOVE : (pick < 96) ? OP_CONTAINS :
                             (pick < 97) ? OP_FLUSH : OP_SPARE_C;
                    default:
                        op = OP_W'($urandom_range(0, 7));
                endcase
                x = narrow ? $urandom_range(0, 3) : $urandom_range(0, 255);
                y = narrow ? $urandom_range(0, 3) : $urandom_range(0, 255);
                pick = $urandom_range(0, 15);
                if (op != OP_ENQUEUE || pick == 0)
                    c = $urandom_range(0, 16383);
                else if (pick == 1)
                    c = $urandom_range(10001, 16383);
                else if (pick == 2)
                    c = $urandom_range(0, 1) ? 10000 : 0;
                else if (pick < 7)
                    c = $urandom_range(0, 7);
                else
                    c = $urandom_range(0, 10000);
                add_cmd(op, x, y, c);
                random_count++;
            end
        end
        total_cmds = pending_cmds.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || cmd_valid || awaited_rsp.size() > 0)
            @(posedge clk);
        // A late or surplus response would still show up in this window.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
